// ===== hw/rtl/rpvg_pkg.sv =====
// Shared types, constants and helper functions for the regular polygon vertex generator.
`timescale 1ns / 1ps

package rpvg_pkg;

    // Geometry limits and arithmetic sizes.
    localparam int MAX_SIDES    = 64;
    localparam int MIN_SIDES    = 3;
    localparam int SIDE_W       = 7;
    localparam int IDX_W        = 6;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 33;
    localparam int CNT_W        = 6;
    localparam int TRIG_W       = 33;
    localparam int PROD_W       = 65;

    // CORDIC start value: inverse of the rotation gain in Q2.30.
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    // Half of one Q2.30 unit, added before the scaling shift.
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 65'sd536870912;

    // Input item of one polygon.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] circumradius;
    } t_in_item;

    // One vertex result.
    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               last_vertex;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_ROT,
        S_MUL_S,
        S_MUL_C,
        S_FIN,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       div_first;
        logic       cordic_load;
        logic       cordic_step;
        logic [4:0] iter;
        logic       mul_s;
        logic       mul_c;
        logic       fin;
        logic       advance;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic radius_pos;
        logic last;
    } t_dp_status;

    // Arctangent of 2^-k in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051D;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2E;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2F9;
            5'd15: v = 30'h0000517C;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A2F;
            5'd19: v = 30'h00000517;
            5'd20: v = 30'h0000028B;
            5'd21: v = 30'h00000145;
            5'd22: v = 30'h000000A2;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000028;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000002;
            5'd29: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // Clamp a 36-bit signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/regular_polygon_vertex_generator_top.sv =====
// Top level: side count register, controller and datapath of the polygon vertex generator.
// After the start transfer the side count division runs first; each vertex then takes
// one load, 30 CORDIC steps, two multiplies, finish and emit.
// One polygon is processed at a time on the single shared CORDIC rotator and multiplier,
// so no new item is taken while busy; a nonpositive radius is taken and leaves it idle.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset is synchronous, active low; it returns to idle and sets the side count to 3.
`timescale 1ns / 1ps

module regular_polygon_vertex_generator_top
    import rpvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_strobe,
    output t_out_item          o_result,
    input  logic               i_cfg_we,
    input  logic [SIDE_W-1:0]  i_cfg_wdata
);

    logic [SIDE_W-1:0] r_side_count;
    t_dp_cmd           cmd;
    t_dp_status        status;

    // Side count configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_count <= SIDE_W'(MIN_SIDES);
        end else if (i_cfg_we) begin
            r_side_count <= i_cfg_wdata;
        end
    end

    rpvg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rpvg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (i_item),
        .i_side_count (r_side_count),
        .o_status     (status),
        .o_result     (o_result),
        .o_strobe     (o_strobe)
    );

`ifndef SYNTH
    // Results are only produced while an item is in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // A nonpositive radius produces no work.
    a_nonpos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.circumradius <= 32'sd0)) |=> !busy)
        else $error("nonpositive radius started a polygon");

    // A positive radius always starts a polygon.
    a_pos_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.circumradius > 32'sd0)) |=> busy)
        else $error("positive radius did not start a polygon");
`endif

endmodule

// ===== hw/rtl/rpvg_datapath.sv =====
// Datapath: side count divider, phase stepper, CORDIC rotator, scaling multiplier and output.
`timescale 1ns / 1ps

module rpvg_datapath
    import rpvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_in_item              i_item,
    input  logic [SIDE_W-1:0]     i_side_count,
    output t_dp_status            o_status,
    output t_out_item             o_result,
    output logic                  o_strobe
);

    // Latched item and clamped side count.
    logic signed [31:0]        r_cx, r_cy, r_r;
    logic [SIDE_W-1:0]         r_n;
    logic [SIDE_W-1:0]         n_clamped;

    // Phase increment floor(2^32 / n) and remainder 2^32 mod n.
    logic [31:0]               r_q0;
    logic [SIDE_W-1:0]         r_rem;
    logic [SIDE_W:0]           div_trial;
    logic                      div_ge;

    // Per-vertex phase state.
    logic [IDX_W-1:0]          r_idx;
    logic [31:0]               r_phase;
    logic [SIDE_W-1:0]         r_vrem;
    logic [SIDE_W:0]           rem_sum;
    logic                      rem_carry;

    // CORDIC state.
    logic signed [TRIG_W-1:0]  r_x, r_y;
    logic signed [31:0]        r_z;
    logic [1:0]                r_quad;
    logic signed [TRIG_W-1:0]  dx, dy;
    logic signed [31:0]        at;
    logic signed [TRIG_W-1:0]  sin_v, cos_v, mul_opnd;

    // Scaling and output.
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [34:0]        scaled;
    logic signed [35:0]        vx_wide, vy_wide;
    logic signed [31:0]        r_vx, r_vy;
    logic                      r_last;
    logic                      r_strobe;

    // Side count clamp to the supported range.
    always_comb begin
        if (i_side_count < SIDE_W'(MIN_SIDES)) begin
            n_clamped = SIDE_W'(MIN_SIDES);
        end else if (i_side_count > SIDE_W'(MAX_SIDES)) begin
            n_clamped = SIDE_W'(MAX_SIDES);
        end else begin
            n_clamped = i_side_count;
        end
    end

    // Restoring division step; the dividend 2^32 has its only set bit first.
    assign div_trial = {(i_cmd.div_first ? {SIDE_W{1'b0}} : r_rem), i_cmd.div_first};
    assign div_ge    = (div_trial >= {1'b0, r_n});

    // Remainder accumulation between vertices.
    assign rem_sum   = {1'b0, r_vrem} + {1'b0, r_rem};
    assign rem_carry = (rem_sum >= {1'b0, r_n});

    // CORDIC shifted terms and angle constant.
    assign dx = r_y >>> i_cmd.iter;
    assign dy = r_x >>> i_cmd.iter;
    assign at = $signed({2'b00, atan_turn(i_cmd.iter)});

    // Quadrant mapping of the rotated vector.
    always_comb begin
        case (r_quad)
            2'd0: begin
                cos_v = r_x;
                sin_v = r_y;
            end
            2'd1: begin
                cos_v = -r_y;
                sin_v = r_x;
            end
            2'd2: begin
                cos_v = -r_x;
                sin_v = -r_y;
            end
            default: begin
                cos_v = r_y;
                sin_v = -r_x;
            end
        endcase
    end

    assign mul_opnd = i_cmd.mul_s ? sin_v : cos_v;

    // Round to nearest, scale back from Q2.30 and combine with the center.
    assign rnd_sum = r_prod + ROUND_HALF;
    assign scaled  = rnd_sum[64:30];
    assign vx_wide = {{4{r_cx[31]}}, r_cx} - {scaled[34], scaled};
    assign vy_wide = {{4{r_cy[31]}}, r_cy} + {scaled[34], scaled};

    // Item capture and division.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx  <= i_item.center_x;
            r_cy  <= i_item.center_y;
            r_r   <= i_item.circumradius;
            r_n   <= n_clamped;
        end
        if (i_cmd.div_step) begin
            r_q0  <= {r_q0[30:0], div_ge};
            r_rem <= div_ge ? SIDE_W'(div_trial - {1'b0, r_n}) : div_trial[SIDE_W-1:0];
        end
    end

    // Vertex index and phase stepping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx   <= '0;
            r_phase <= '0;
            r_vrem  <= '0;
        end else if (i_cmd.advance) begin
            r_idx   <= r_idx + IDX_W'(1);
            r_phase <= r_phase + r_q0 + 32'(rem_carry);
            r_vrem  <= rem_carry ? SIDE_W'(rem_sum - {1'b0, r_n}) : rem_sum[SIDE_W-1:0];
        end
    end

    // CORDIC rotation, one step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_load) begin
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({2'b00, r_phase[29:0]});
            r_quad <= r_phase[31:30];
        end else if (i_cmd.cordic_step) begin
            if (!r_z[31]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
        end
    end

    // Shared multiplier: sine product first, then cosine product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_s || i_cmd.mul_c) begin
            r_prod <= PROD_W'(r_r) * PROD_W'(mul_opnd);
        end
        if (i_cmd.mul_c) begin
            r_vx <= sat32(vx_wide);
        end
        if (i_cmd.fin) begin
            r_vy   <= sat32(vy_wide);
            r_last <= o_status.last;
        end
    end

    // Result strobe for the cycle after the y coordinate is finished.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.fin;
        end
    end

    assign o_status.radius_pos = !i_item.circumradius[31] && (|i_item.circumradius);
    assign o_status.last       = ({1'b0, r_idx} == (r_n - SIDE_W'(1)));

    assign o_result.vertex_x    = r_vx;
    assign o_result.vertex_y    = r_vy;
    assign o_result.last_vertex = r_last;
    assign o_strobe             = r_strobe;

endmodule

// ===== hw/rtl/rpvg_ctrl.sv =====
// Controller state machine that sequences division, rotation, scaling and output.
`timescale 1ns / 1ps

module rpvg_ctrl
    import rpvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_dp_status  i_status,
    output t_dp_cmd     o_cmd,
    output logic        o_busy
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start && i_status.radius_pos) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_LOAD: begin
                n_cnt   = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_MUL_S;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_MUL_S: n_state = S_MUL_C;
            S_MUL_C: n_state = S_FIN;
            S_FIN:   n_state = S_EMIT;
            S_EMIT: begin
                n_state = i_status.last ? S_IDLE : S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd           = '0;
        o_cmd.iter      = r_cnt[4:0];
        case (r_state)
            S_IDLE:  o_cmd.load        = i_start;
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_cnt == '0);
            end
            S_LOAD:  o_cmd.cordic_load = 1'b1;
            S_ROT:   o_cmd.cordic_step = 1'b1;
            S_MUL_S: o_cmd.mul_s       = 1'b1;
            S_MUL_C: o_cmd.mul_c       = 1'b1;
            S_FIN:   o_cmd.fin         = 1'b1;
            S_EMIT:  o_cmd.advance     = 1'b1;
            default: o_cmd             = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTH
    // A result cycle always follows the finishing cycle of a vertex.
    a_emit_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ($past(r_state) == S_FIN))
        else $error("emit state entered without finishing a vertex");

    // The rotation never runs past its last step.
    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_cnt < CNT_W'(CORDIC_STEPS)))
        else $error("rotation step counter out of range");

    // Division only leaves toward the first vertex load.
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_LOAD))
        else $error("division left to an unexpected state");
`endif

endmodule

// ===== test/rpvg_vertex_checker.sv =====
// Checker that predicts and compares the vertices of the polygon vertex generator.
`timescale 1ns / 1ps

module rpvg_vertex_checker
    import rpvg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_in_item          i_item,
    input  logic              i_strobe,
    input  t_out_item         i_result,
    input  logic              i_cfg_we,
    input  logic [SIDE_W-1:0] i_cfg_wdata,
    output int                o_pending,
    output int                o_errors,
    output int                o_vertices
);

    // Rotation angles of the CORDIC steps, in units of 2^-32 turn.
    longint atan_lut [0:CORDIC_STEPS-1];

    // Quadrant selected by the top two phase bits.
    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } t_quadrant;

    localparam longint TRIG_GAIN = 64'sd652032874;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    logic [SIDE_W-1:0] side_reg;
    t_out_item         vertex_q [$];
    int                error_count;
    int                vertex_count;

    initial begin
        atan_lut = '{
            64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
            64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
            64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
        };
        error_count  = 0;
        vertex_count = 0;
    end

    // Sine and cosine in Q2.30 of a phase given in turns; the low 30 bits rotate,
    // the top two bits fold the result into its quadrant.
    function automatic void cordic_sin_cos(input logic [31:0] phase,
                                           output longint sin_v, output longint cos_v);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = TRIG_GAIN;
        y = 0;
        z = {34'd0, phase[29:0]};
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_lut[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_lut[k];
            end
        end
        case (t_quadrant'(phase[31:30]))
            QUAD_FIRST: begin
                cos_v = x;
                sin_v = y;
            end
            QUAD_SECOND: begin
                cos_v = -y;
                sin_v = x;
            end
            QUAD_THIRD: begin
                cos_v = -x;
                sin_v = -y;
            end
            default: begin
                cos_v = y;
                sin_v = -x;
            end
        endcase
    endfunction

    // Radius times a Q2.30 factor, rounded to nearest with ties upward.
    function automatic longint scale_q30(input longint r, input longint t);
        return (r * t + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > COORD_MAX) return 32'sh7FFFFFFF;
        if (v < COORD_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Queue every vertex that one accepted polygon should produce.
    function automatic void predict_polygon(input t_in_item it);
        int unsigned     n;
        longint          cx;
        longint          cy;
        longint          r;
        longint          s;
        longint          c;
        longint unsigned num;
        logic [31:0]     phase;
        t_out_item       v;
        n  = 32'(side_reg);
        if (n < MIN_SIDES) n = MIN_SIDES;
        if (n > MAX_SIDES) n = MAX_SIDES;
        cx = 64'($signed(it.center_x));
        cy = 64'($signed(it.center_y));
        r  = 64'($signed(it.circumradius));
        if (r <= 0) return;
        for (int unsigned i = 0; i < n; i++) begin
            num   = 64'(i) << 32;
            phase = 32'(num / n);
            cordic_sin_cos(phase, s, c);
            v.vertex_x    = clamp32(cx - scale_q30(r, s));
            v.vertex_y    = clamp32(cy + scale_q30(r, c));
            v.last_vertex = (i == n - 1);
            vertex_q.insert(vertex_q.size(), v);
        end
    endfunction

    // Compare one vertex transfer against the oldest prediction.
    function automatic void check_vertex(input t_out_item got);
        t_out_item want;
        if (vertex_q.size() == 0) begin
            $display("%0t: unexpected vertex x=%0d y=%0d last=%b", $time,
                     got.vertex_x, got.vertex_y, got.last_vertex);
            error_count++;
            return;
        end
        want = vertex_q.pop_front();
        vertex_count++;
        if (got.vertex_x !== want.vertex_x) begin
            $display("%0t: vertex_x mismatch: expected %0d, got %0d", $time,
                     want.vertex_x, got.vertex_x);
            error_count++;
        end
        if (got.vertex_y !== want.vertex_y) begin
            $display("%0t: vertex_y mismatch: expected %0d, got %0d", $time,
                     want.vertex_y, got.vertex_y);
            error_count++;
        end
        if (got.last_vertex !== want.last_vertex) begin
            $display("%0t: last_vertex mismatch: expected %b, got %b", $time,
                     want.last_vertex, got.last_vertex);
            error_count++;
        end
    endfunction

    // Watch the register port, the result strobe and the start transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg = SIDE_W'(MIN_SIDES);
            vertex_q.delete();
        end else begin
            if (i_cfg_we) begin
                side_reg = i_cfg_wdata;
            end
            if ($isunknown(i_strobe)) begin
                $display("%0t: result strobe is unknown", $time);
                error_count++;
            end else if (i_strobe) begin
                check_vertex(i_result);
            end
            if (i_start && !i_busy) begin
                predict_polygon(i_item);
            end
        end
        o_pending  <= vertex_q.size();
        o_errors   <= error_count;
        o_vertices <= vertex_count;
    end

endmodule

// ===== test/tb_regular_polygon_vertex_generator_top.sv =====
// Testbench top: clock, reset, polygon and side-count stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_regular_polygon_vertex_generator_top;
    import rpvg_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int          RANDOM_POLYGONS = 115;
    localparam int          SETTLE_CYCLES   = 80;
    localparam int          BATCH_SIZE      = 10;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in_item          i_item;
    logic              o_strobe;
    t_out_item         o_result;
    logic              i_cfg_we;
    logic [SIDE_W-1:0] i_cfg_wdata;

    int          pending;
    int          errors;
    int          vertices;
    int unsigned cycles = 0;
    int          sent;
    int          nonpositive;

    regular_polygon_vertex_generator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rpvg_vertex_checker u_vertex_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (i_item),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_vertices  (vertices)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Present one polygon and hold it until the start transfer completes.
    task automatic send_polygon(input t_in_item it);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sent++;
        if ($signed(it.circumradius) <= 0) nonpositive++;
    endtask

    task automatic pause_cycles(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending until every predicted vertex has arrived and the block is idle.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_sides(input logic [SIDE_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_in_item make_polygon(input logic [31:0] cx, input logic [31:0] cy,
                                              input logic [31:0] r);
        t_in_item it;
        it.center_x     = cx;
        it.center_y     = cy;
        it.circumradius = r;
        return it;
    endfunction

    // Mostly small centers and radii, with full-range values and extremes mixed in.
    function automatic logic [31:0] random_center();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            6, 7, 8:          v = $urandom();
            default:          v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] random_radius();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(1, 32'h0010_0000);
            5, 6:          v = {1'b0, 31'($urandom())};
            7:             v = $urandom();
            8:             v = -$urandom_range(0, 1000);
            default: begin
                case ($urandom_range(0, 2))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
        endcase
        return v;
    endfunction

    // Small side counts dominate to keep the run short; the clamped ends still appear.
    function automatic logic [SIDE_W-1:0] random_sides();
        logic [SIDE_W-1:0] v;
        case ($urandom_range(0, 19))
            14, 15:  v = SIDE_W'($urandom_range(0, MIN_SIDES - 1));
            16:      v = SIDE_W'(MAX_SIDES);
            17:      v = SIDE_W'($urandom_range(MAX_SIDES + 1, 127));
            18, 19:  v = SIDE_W'($urandom_range(11, 40));
            default: v = SIDE_W'($urandom_range(MIN_SIDES, 10));
        endcase
        return v;
    endfunction

    initial begin
        t_in_item it;
        int       issued;
        int       batch;
        int       idle_pct;

        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        sent        = 0;
        nonpositive = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed polygons at the reset side count: smallest radius, nonpositive
        // radii, and saturation in both directions.
        send_polygon(make_polygon(32'h0, 32'h0, 32'h1));
        send_polygon(make_polygon(32'h0, 32'h0, 32'h0));
        send_polygon(make_polygon(32'h0, 32'h0, 32'hFFFF_FFFF));
        send_polygon(make_polygon(32'h0, 32'h0, 32'h8000_0000));
        send_polygon(make_polygon(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_polygon(make_polygon(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_polygon(make_polygon(32'h0001_0000, 32'hFFFE_0000, 32'h0005_0000));

        // Side counts below three, all four quadrants, the maximum and above it.
        write_sides(7'd0);
        send_polygon(make_polygon(32'h0003_0000, 32'h0004_0000, 32'h0002_8000));
        write_sides(7'd1);
        send_polygon(make_polygon(32'hFFF0_0000, 32'h0010_0000, 32'h0000_4000));
        write_sides(7'd2);
        send_polygon(make_polygon(32'h1234_5678, 32'h8765_4321, 32'h0100_0000));
        write_sides(7'd4);
        send_polygon(make_polygon(32'h7FFF_0000, 32'h8001_0000, 32'h7FFF_FFFF));
        send_polygon(make_polygon(32'h0, 32'h0, 32'h0001_0000));
        write_sides(7'd6);
        send_polygon(make_polygon(32'h0000_8000, 32'hFFFF_8000, 32'h000A_0000));
        write_sides(7'd64);
        send_polygon(make_polygon(32'h0, 32'h0, 32'h7FFF_FFFF));
        write_sides(7'd127);
        send_polygon(make_polygon(32'h4000_0000, 32'hC000_0000, 32'h0020_0000));

        // Random polygons in batches per side count; the sender idles per cycle at a
        // rate that changes by phase.
        issued = 0;
        batch  = 0;
        while (issued < RANDOM_POLYGONS) begin
            if (batch == 0) begin
                write_sides(random_sides());
                batch = BATCH_SIZE;
            end
            it.center_x     = random_center();
            it.center_y     = random_center();
            it.circumradius = random_radius();
            if (issued < 38) begin
                idle_pct = 27;
            end else if (issued < 76) begin
                idle_pct = 62;
            end else begin
                idle_pct = 0;
            end
            while ($urandom_range(1, 100) <= idle_pct) begin
                pause_cycles(1);
            end
            if (idle_pct != 0 && $urandom_range(1, 40) == 1) begin
                wait_drained();
            end
            send_polygon(it);
            issued++;
            batch--;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run summary: %0d polygons sent, %0d of them with nonpositive radius,",
                 sent, nonpositive);
        $display("%0d vertices compared; side counts covered below three, 3 to 64 and above 64.",
                 vertices);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
